// ----- hdl/deps_pkg.sv -----
// Shared constants for the diagonal edge pixel smoother.
// Used by the top level; no dependencies.
package deps_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_DIVISOR_SCALE = 2'd2;

   // Register reset values
   localparam logic [8:0]  WIDTH_RESET = 9'd256;
   localparam logic [8:0]  HEIGHT_RESET = 9'd256;
   localparam logic [15:0] SCALE_RESET = 16'd842;

   // Alpha above this makes a side pixel eligible
   localparam logic [7:0] ALPHA_THRESH = 8'd128;

   // Divider geometry: channel sums and divisors are 10 bits
   localparam int SUM_W = 10;

   typedef logic [31:0] pixel_type;

endpackage

// ----- hdl/diagonal_edge_pixel_smoother_core.sv -----
// Top level of the diagonal edge pixel smoother: line store, 3x3 window,
// smoothing datapath and stream ports. Uses deps_pkg and deps_ram.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------------
//  req     | req_tvalid/req_tready/req_tdata| pixel_rgba
//  rsp     | rsp_tvalid/rsp_tready/rsp_tdata| result_rgba, out_col, out_row; tlast
//  csr     | csr_valid/csr_ready            | csr_index, csr_data
//
// A request is accepted, then both line store rows are read (one read port)
// and the pixel is written back; a candidate slot with no output is skipped,
// and each emitted pixel passes classify, divisor, 10 restoring divider steps
// and two blend stages. Reset clears the window, position counters and output
// valid flag; the line store is not cleared. A stalled rsp side holds the blend
// stage until the output register frees up; a request is taken only while idle.
module diagonal_edge_pixel_smoother_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_rgba
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] result_rgba, [39:32] out_col, [47:40] out_row
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = (RW + 1 > 9) ? RW + 1 : 9;
   localparam int DEPTH = 2 * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = deps_pkg::SUM_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1  = 3'd1;
   localparam logic [2:0] S_RD2  = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_DSET = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_BL1  = 3'd6;
   localparam logic [2:0] S_BL2  = 3'd7;

   // Configuration registers
   logic [8:0]  width_ff;
   logic [8:0]  height_ff;
   logic [15:0] scale_ff;

   // Control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]    k_ff, k_in;
   logic [3:0]    emv_ff, emv_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers
   deps_pkg::pixel_type win_ff [3][3];
   deps_pkg::pixel_type cur_ff, top_ff, centre_ff;
   logic [CW-1:0]       c_ff;
   logic [RW-1:0]       r_ff;
   logic                top_ok_ff, mid_ok_ff;
   logic [SW-1:0]       num_ff [4];
   logic [SW-1:0]       rem_ff [4];
   logic [SW-1:0]       quo_ff [4];
   logic [SW-1:0]       div_ff;
   logic [2:0]          n_ff;
   logic                last_ff;
   logic [7:0]          sm_ff [4];
   logic [15:0]         prod_ff [4];
   logic [47:0]         rsp_data_ff;
   logic                rsp_last_ff;

   // Effective geometry
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   always_comb begin
      w_eff = WW'(width_ff);
      if (w_eff == '0) begin
         w_eff = WW'(1);
      end else if (w_eff > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end
      h_eff = HW'(height_ff);
      if (h_eff == '0) begin
         h_eff = HW'(1);
      end else if (h_eff > HW'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end
   end

   // Normalize the position of the incoming request and plan its outputs
   logic [WW-1:0] c0, c1;
   logic [HW-1:0] r0, r1;
   logic [CW-1:0] c_now, col_nx;
   logic [RW-1:0] r_now, row_nx;
   logic [3:0]    emv_now;

   always_comb begin
      c0 = WW'(col_ff);
      r0 = HW'(row_ff);
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + HW'(1);
      end
      if (r0 >= h_eff) begin
         r0 = '0;
      end
      c_now = c0[CW-1:0];
      r_now = r0[RW-1:0];
      c1 = c0 + WW'(1);
      r1 = r0;
      if (c1 >= w_eff) begin
         c1 = '0;
         r1 = r0 + HW'(1);
         if (r1 >= h_eff) begin
            r1 = '0;
         end
      end
      col_nx = c1[CW-1:0];
      row_nx = r1[RW-1:0];
      // bit 1 selects row r (else r-1), bit 0 selects column c (else c-1)
      emv_now[0] = (r0 != '0) && (c0 != '0);
      emv_now[1] = (r0 != '0) && (c0 == w_eff - WW'(1));
      emv_now[2] = (r0 == h_eff - HW'(1)) && (c0 != '0);
      emv_now[3] = (r0 == h_eff - HW'(1)) && (c0 == w_eff - WW'(1));
   end

   // Line store addressing
   function automatic logic [AW-1:0] ls_addr(input logic rbit, input logic [CW-1:0] c);
      ls_addr = AW'(c) + (rbit ? AW'(MAX_WIDTH) : AW'(0));
   endfunction

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   deps_pkg::pixel_type ram_rd_data;
   logic          req_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign ram_rd_en = req_fire || (state_ff == S_RD1);
   assign ram_rd_addr = (state_ff == S_RD1) ? ls_addr(~r_ff[0], c_ff) : ls_addr(r_now[0], c_now);
   assign ram_wr_en = (state_ff == S_RD1);
   assign ram_wr_addr = ls_addr(r_ff[0], c_ff);

   deps_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Window access; grid index 3 lies beyond the frame edge
   function automatic deps_pkg::pixel_type wpx(
      input deps_pkg::pixel_type w [3][3], input logic [1:0] gx, input logic [1:0] gy);
      if (gx == 2'd3 || gy == 2'd3) begin
         wpx = '0;
      end else begin
         wpx = w[gy][gx];
      end
   endfunction

   // Classify the four diagonals around the selected centre
   logic [1:0]    cx, cy;
   logic [SW-1:0] sum_c [4];
   logic [2:0]    n_c;
   deps_pkg::pixel_type centre_c;
   logic          last_c;

   always_comb begin
      logic [1:0] sx, ox, sy, oy;
      deps_pkg::pixel_type s;
      logic q;
      cx = k_ff[0] ? 2'd2 : 2'd1;
      cy = k_ff[1] ? 2'd2 : 2'd1;
      centre_c = wpx(win_ff, cx, cy);
      n_c = '0;
      for (int ch = 0; ch < 4; ch++) begin
         sum_c[ch] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         sx = (i >= 2) ? cx + 2'd1 : cx - 2'd1;
         ox = (i >= 2) ? cx - 2'd1 : cx + 2'd1;
         sy = (i % 2 == 1) ? cy + 2'd1 : cy - 2'd1;
         oy = (i % 2 == 1) ? cy - 2'd1 : cy + 2'd1;
         s = wpx(win_ff, sx, cy);
         q = (s[31:24] > deps_pkg::ALPHA_THRESH) && (s == wpx(win_ff, cx, sy)) &&
             ((s != wpx(win_ff, sx, sy)) || (s != wpx(win_ff, ox, sy)) ||
              (s != wpx(win_ff, sx, oy)));
         if (q) begin
            n_c = n_c + 3'd1;
            for (int ch = 0; ch < 4; ch++) begin
               sum_c[ch] = sum_c[ch] + SW'(s[8*ch +: 8]);
            end
         end
      end
      unique case (k_ff)
         2'd0:    last_c = (emv_ff[3:1] == 3'b000);
         2'd1:    last_c = (emv_ff[3:2] == 2'b00);
         2'd2:    last_c = !emv_ff[3];
         default: last_c = 1'b1;
      endcase
   end

   // Divisor from count and scale
   logic [18:0]   dprod;
   logic [SW-1:0] div_c;
   assign dprod = 19'(n_ff) * 19'(scale_ff);
   assign div_c = (dprod[17:8] == '0) ? SW'(1) : dprod[17:8];

   // One restoring division step per channel
   logic [SW:0]   trial [4];
   logic          qbit [4];
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         trial[ch] = {rem_ff[ch], num_ff[ch][SW-1]};
         qbit[ch] = (trial[ch] >= {1'b0, div_ff});
      end
   end

   // Blend: saturate quotient, then t*(255-sa)
   logic [7:0]  sm_c [4];
   logic [15:0] prod_c [4];
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         sm_c[ch] = (quo_ff[ch] > SW'(255)) ? 8'hFF : quo_ff[ch][7:0];
      end
      for (int ch = 0; ch < 4; ch++) begin
         prod_c[ch] = 16'(centre_ff[8*ch +: 8]) * 16'(8'hFF - sm_c[3]);
      end
   end

   // Divide by 255 via reciprocal and add the smoothed colour
   deps_pkg::pixel_type blend_c;
   always_comb begin
      logic [16:0] t;
      logic [8:0]  v;
      for (int ch = 0; ch < 4; ch++) begin
         t = 17'(prod_ff[ch]) + 17'd1 + 17'(prod_ff[ch][15:8]);
         v = 9'(sm_ff[ch]) + 9'(t[15:8]);
         blend_c[8*ch +: 8] = v[8] ? 8'hFF : v[7:0];
      end
      if (n_ff == '0) begin
         blend_c = centre_ff;
      end
   end

   // Output position
   logic [CW-1:0]  ox_c;
   logic [RW-1:0]  oy_c;
   logic [CW+7:0]  ox_w;
   logic [RW+7:0]  oy_w;
   logic           out_free;
   assign ox_c = k_ff[0] ? c_ff : c_ff - CW'(1);
   assign oy_c = k_ff[1] ? r_ff : r_ff - RW'(1);
   assign ox_w = (CW+8)'(ox_c);
   assign oy_w = (RW+8)'(oy_c);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      k_in = k_ff;
      emv_in = emv_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               col_in = col_nx;
               row_in = row_nx;
               emv_in = emv_now;
               state_in = S_RD1;
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            k_in = 2'd0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emv_ff[k_ff]) begin
               state_in = S_DSET;
            end else if (k_ff == 2'd3) begin
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_DSET: begin
            cnt_in = 4'(SW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               state_in = S_BL1;
            end
         end
         S_BL1: state_in = S_BL2;
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_EMIT;
               end
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         k_ff <= '0;
         emv_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff <= deps_pkg::WIDTH_RESET;
         height_ff <= deps_pkg::HEIGHT_RESET;
         scale_ff <= deps_pkg::SCALE_RESET;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         k_ff <= k_in;
         emv_ff <= emv_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               deps_pkg::REG_IMAGE_WIDTH:   width_ff <= csr_data[8:0];
               deps_pkg::REG_IMAGE_HEIGHT:  height_ff <= csr_data[8:0];
               deps_pkg::REG_DIVISOR_SCALE: scale_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (state_ff == S_RD2) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= (c_ff == '0) ? '0 : win_ff[i][1];
            win_ff[i][1] <= (c_ff == '0) ? '0 : win_ff[i][2];
         end
         win_ff[0][2] <= top_ok_ff ? top_ff : '0;
         win_ff[1][2] <= mid_ok_ff ? ram_rd_data : '0;
         win_ff[2][2] <= cur_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff <= req_tdata;
         c_ff <= c_now;
         r_ff <= r_now;
         top_ok_ff <= (r0 >= HW'(2));
         mid_ok_ff <= (r0 != '0);
      end
      if (state_ff == S_RD1) begin
         top_ff <= ram_rd_data;
      end
      if (state_ff == S_EMIT) begin
         centre_ff <= centre_c;
         n_ff <= n_c;
         last_ff <= last_c;
         for (int ch = 0; ch < 4; ch++) begin
            num_ff[ch] <= sum_c[ch];
         end
      end
      if (state_ff == S_DSET) begin
         div_ff <= div_c;
         for (int ch = 0; ch < 4; ch++) begin
            rem_ff[ch] <= '0;
            quo_ff[ch] <= '0;
         end
      end
      if (state_ff == S_DIV) begin
         for (int ch = 0; ch < 4; ch++) begin
            rem_ff[ch] <= qbit[ch] ? SW'(trial[ch] - {1'b0, div_ff}) : trial[ch][SW-1:0];
            quo_ff[ch] <= {quo_ff[ch][SW-2:0], qbit[ch]};
            num_ff[ch] <= {num_ff[ch][SW-2:0], 1'b0};
         end
      end
      if (state_ff == S_BL1) begin
         for (int ch = 0; ch < 4; ch++) begin
            sm_ff[ch] <= sm_c[ch];
            prod_ff[ch] <= prod_c[ch];
         end
      end
      if (state_ff == S_BL2 && out_free) begin
         rsp_data_ff <= {oy_w[7:0], ox_w[7:0], blend_c};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign csr_ready = 1'b1;

   // Accepted request always starts the line store reads
   a_req_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_RD1))
      else $error("request did not start line store read");

   // Divisor is never zero while dividing
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("zero divisor in divider");

   // Divider step count stays in range
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= 4'(SW - 1)))
      else $error("divider step count out of range");

   // A result is loaded only from the blend stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !$past(reset) && $past(rsp_valid_ff) == 1'b0 && rsp_valid_in)
      |-> (state_ff == S_BL2))
      else $error("result loaded outside blend stage");

endmodule

// ----- hdl/deps_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module deps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
